>>> rtl/akd_pkg.sv
// Shared types and constants for the Atkinson error-diffusion dither unit.
package akd_pkg;

  localparam int unsigned DefMaxWidth = 256;
  localparam int unsigned SampleW     = 8;
  localparam int unsigned ErrW        = 5;
  localparam int unsigned RowW        = 12;
  localparam int unsigned ColumnW     = 8;
  localparam int unsigned WidthRegW   = 9;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = 12;
  localparam int unsigned InDataW     = 8;
  localparam int unsigned OutDataW    = 24;
  localparam int unsigned OutPadW     = OutDataW - RowW - ColumnW - 1;

  localparam logic [WidthRegW-1:0] WidthReset  = 9'd200;
  localparam logic [RowW-1:0]      HeightReset = 12'd1;
  localparam logic [SampleW-1:0]   WhiteLevel  = 8'd255;

  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth  = 1'b0,
    CfgImageHeight = 1'b1
  } cfg_reg_e;

  // One stored entry per pixel: its quantization error and whether it spreads right.
  typedef struct packed {
    logic                   gate;
    logic signed [ErrW-1:0] err;
  } err_word_t;

  // Per-pixel control that travels from the raster counters to the error stage.
  typedef struct packed {
    logic last;  // final pixel of the image
    logic ok0;   // row above holds column x
    logic ok1;   // row above holds column x+1
    logic ok2;   // row two above holds column x
    logic f1;    // x >= 1
    logic f2;    // x >= 2
    logic g1;    // x+1 inside the row width
    logic g2;    // x+2 inside the row width
  } pix_flags_t;

endpackage

>>> rtl/akd_error_ram.sv
// Error store: one write port, two registered read ports with write-to-read forwarding.
module akd_error_ram #(
  parameter int unsigned Depth = 3 * akd_pkg::DefMaxWidth,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  akd_pkg::err_word_t  wdata_i,
  input  logic                re_i,
  input  logic [AddrW-1:0]    raddr_a_i,
  input  logic [AddrW-1:0]    raddr_b_i,
  output akd_pkg::err_word_t  rdata_a_o,
  output akd_pkg::err_word_t  rdata_b_o
);

  akd_pkg::err_word_t mem_q [Depth];
  akd_pkg::err_word_t rd_a_q, rd_b_q, wd_q;
  logic               fwd_a_q, fwd_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_a_q <= mem_q[raddr_a_i];
      rd_b_q <= mem_q[raddr_b_i];
      wd_q   <= wdata_i;
    end
  end

  // Flag reads that hit the entry being written on the same edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_a_q <= 1'b0;
      fwd_b_q <= 1'b0;
    end else if (re_i) begin
      fwd_a_q <= we_i && (waddr_i == raddr_a_i);
      fwd_b_q <= we_i && (waddr_i == raddr_b_i);
    end
  end

  assign rdata_a_o = fwd_a_q ? wd_q : rd_a_q;
  assign rdata_b_o = fwd_b_q ? wd_q : rd_b_q;

endmodule

>>> rtl/akd_scan.sv
// Raster counters, row bookkeeping and error store addressing for each accepted pixel.
module akd_scan #(
  parameter int unsigned MaxWidth = akd_pkg::DefMaxWidth,
  parameter int unsigned XW       = $clog2(MaxWidth),
  parameter int unsigned AddrW    = $clog2(3 * MaxWidth)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               accept_i,
  input  logic [akd_pkg::WidthRegW-1:0]      image_width_i,
  input  logic [akd_pkg::RowW-1:0]           image_height_i,
  output logic [XW-1:0]                      x_o,
  output logic [akd_pkg::RowW-1:0]           y_o,
  output akd_pkg::pix_flags_t                flags_o,
  output logic [AddrW-1:0]                   waddr_o,
  output logic [AddrW-1:0]                   raddr_a_o,
  output logic [AddrW-1:0]                   raddr_b_o
);

  localparam int unsigned CmpW0 = $clog2(MaxWidth + 3);
  localparam int unsigned CmpW  = ((CmpW0 > akd_pkg::WidthRegW) ? CmpW0
                                                                : akd_pkg::WidthRegW) + 1;
  localparam logic [AddrW-1:0] Base1 = AddrW'(MaxWidth);
  localparam logic [AddrW-1:0] Base2 = AddrW'(2 * MaxWidth);

  function automatic logic [AddrW-1:0] bank_base(input logic [1:0] b);
    case (b)
      2'd1:    return Base1;
      2'd2:    return Base2;
      default: return '0;
    endcase
  endfunction

  function automatic logic [1:0] bank_next(input logic [1:0] b);
    return (b == 2'd2) ? 2'd0 : b + 2'd1;
  endfunction

  function automatic logic [1:0] bank_prev(input logic [1:0] b);
    return (b == 2'd0) ? 2'd2 : b - 2'd1;
  endfunction

  logic [XW-1:0]            col_q, col_d;
  logic [akd_pkg::RowW-1:0] row_q, row_d;
  logic                     prev_valid_q, prev_valid_d;
  logic [XW-1:0]            prev_last_q, prev_last_d;
  logic                     prev2_valid_q, prev2_valid_d;
  logic [XW-1:0]            prev2_last_q, prev2_last_d;
  logic [XW-1:0]            cur_last_q;
  logic [1:0]               bank_q, bank_d;

  logic [CmpW-1:0]          w_wide, w_eff, x_w, x1_w, x2_w;
  logic [akd_pkg::RowW-1:0] h_eff;
  logic [XW-1:0]            x, xp;
  logic [akd_pkg::RowW-1:0] y;
  logic                     row_start, last, row_end;

  assign w_wide = CmpW'(image_width_i);
  assign w_eff  = (w_wide == '0) ? CmpW'(1)
                : (w_wide > CmpW'(MaxWidth)) ? CmpW'(MaxWidth) : w_wide;
  assign h_eff  = (image_height_i == '0) ? akd_pkg::RowW'(1) : image_height_i;

  always_comb begin
    x = col_q;
    y = row_q;
    // Wrap to a new row when the width shrank under the column count.
    if (CmpW'(col_q) >= w_eff) begin
      x = '0;
      y = row_q + 1'b1;
    end
    // Restart the image when the height shrank under the row count.
    if (y >= h_eff) begin
      x = '0;
      y = '0;
    end
  end

  assign x_w       = CmpW'(x);
  assign x1_w      = x_w + CmpW'(1);
  assign x2_w      = x_w + CmpW'(2);
  assign row_start = (x == '0);
  assign row_end   = (x1_w == w_eff);
  assign last      = row_end && (({1'b0, y} + 1'b1) == {1'b0, h_eff});
  assign xp        = (x == XW'(MaxWidth - 1)) ? x : x + 1'b1;

  always_comb begin
    prev_valid_d  = prev_valid_q;
    prev_last_d   = prev_last_q;
    prev2_valid_d = prev2_valid_q;
    prev2_last_d  = prev2_last_q;
    bank_d        = bank_q;
    if (row_start) begin
      prev_valid_d  = (y != '0);
      prev_last_d   = cur_last_q;
      prev2_valid_d = (y != '0) && prev_valid_q;
      prev2_last_d  = prev_last_q;
      bank_d        = bank_next(bank_q);
    end
  end

  always_comb begin
    if (last) begin
      col_d = '0;
      row_d = '0;
    end else if (row_end) begin
      col_d = '0;
      row_d = y + 1'b1;
    end else begin
      col_d = XW'(x1_w);
      row_d = y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q         <= '0;
      row_q         <= '0;
      prev_valid_q  <= 1'b0;
      prev_last_q   <= '0;
      prev2_valid_q <= 1'b0;
      prev2_last_q  <= '0;
      cur_last_q    <= '0;
      bank_q        <= '0;
    end else if (accept_i) begin
      col_q         <= col_d;
      row_q         <= row_d;
      prev_valid_q  <= prev_valid_d;
      prev_last_q   <= prev_last_d;
      prev2_valid_q <= prev2_valid_d;
      prev2_last_q  <= prev2_last_d;
      cur_last_q    <= x;
      bank_q        <= bank_d;
    end
  end

  assign x_o = x;
  assign y_o = y;

  always_comb begin
    flags_o.last = last;
    flags_o.ok0  = prev_valid_d && (x <= prev_last_d);
    flags_o.ok1  = prev_valid_d && (x1_w <= CmpW'(prev_last_d));
    flags_o.ok2  = prev2_valid_d && (x <= prev2_last_d);
    flags_o.f1   = (x != '0);
    flags_o.f2   = (x_w >= CmpW'(2));
    flags_o.g1   = (x1_w < w_eff);
    flags_o.g2   = (x2_w < w_eff);
  end

  assign waddr_o   = bank_base(bank_d) + AddrW'(x);
  assign raddr_a_o = bank_base(bank_next(bank_d)) + AddrW'(x);
  assign raddr_b_o = bank_base(bank_prev(bank_d)) + AddrW'(xp);

endmodule

>>> rtl/akd_quant.sv
// Error summing, clamp, threshold and error split, with the in-row neighbor registers.
module akd_quant (
  input  logic                          clk_i,
  input  logic                          adv_i,
  input  logic [akd_pkg::SampleW-1:0]   sample_i,
  input  akd_pkg::pix_flags_t           flags_i,
  input  akd_pkg::err_word_t            rd_a_i,
  input  akd_pkg::err_word_t            rd_b_i,
  output logic                          white_o,
  output akd_pkg::err_word_t            wdata_o
);

  localparam int unsigned SumW = 11;

  logic signed [akd_pkg::ErrW-1:0] right1_q, right2_q, right2d_q, left_q;
  akd_pkg::err_word_t              hold_q, first_q, cur_down;

  logic signed [akd_pkg::ErrW-1:0] e_up2, e_up, e_upl, e_upr, e_r1, e_r2, err;
  logic signed [SumW-1:0]          sum_s;
  logic [akd_pkg::SampleW-1:0]     val;
  logic signed [akd_pkg::SampleW:0] diff;
  logic [akd_pkg::SampleW-1:0]     mag;
  logic [3:0]                      q;

  // Row above at column x: prefetched by the previous pixel, or the saved row head.
  assign cur_down = flags_i.f1 ? hold_q : first_q;

  assign e_up2 = flags_i.ok2 ? rd_a_i.err : '0;
  assign e_up  = flags_i.ok0 ? cur_down.err : '0;
  assign e_upr = flags_i.ok1 ? rd_b_i.err : '0;
  assign e_upl = flags_i.f1 ? left_q : '0;
  assign e_r1  = flags_i.f1 ? right1_q : '0;
  assign e_r2  = flags_i.f2 ? right2d_q : '0;

  assign sum_s = SumW'($signed({3'b000, sample_i})) + SumW'(e_up2) + SumW'(e_up)
               + SumW'(e_upr) + SumW'(e_upl) + SumW'(e_r1) + SumW'(e_r2);

  always_comb begin
    if (sum_s < 0) begin
      val = '0;
    end else if (sum_s > SumW'($signed({3'b000, akd_pkg::WhiteLevel}))) begin
      val = akd_pkg::WhiteLevel;
    end else begin
      val = sum_s[akd_pkg::SampleW-1:0];
    end
  end

  assign white_o = val[akd_pkg::SampleW-1];

  always_comb begin
    diff = $signed({1'b0, val});
    if (white_o) begin
      diff = $signed({1'b0, val}) - $signed({1'b0, akd_pkg::WhiteLevel});
    end
    mag = diff[akd_pkg::SampleW] ? akd_pkg::SampleW'(-diff) : diff[akd_pkg::SampleW-1:0];
    // Divide by eight, truncated toward zero.
    q   = mag[6:3];
    err = diff[akd_pkg::SampleW] ? -$signed({1'b0, q}) : $signed({1'b0, q});
  end

  assign wdata_o.gate = flags_i.g1;
  assign wdata_o.err  = err;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      right1_q  <= flags_i.g1 ? err : '0;
      right2_q  <= flags_i.g2 ? err : '0;
      right2d_q <= right2_q;
      hold_q    <= rd_b_i;
      left_q    <= (flags_i.ok0 && cur_down.gate) ? cur_down.err : '0;
      if (!flags_i.f1) begin
        first_q <= wdata_o;
      end
    end
  end

endmodule

>>> rtl/atkinson_error_diffusion_dither_unit.sv
// Atkinson dither: takes one gray sample per cycle in raster order and returns one
// black or white pixel with its column, row and an end-of-image mark. Throughput is
// one pixel per clock; pixels pass the error stage and output registers and the input
// stalls only while the output register is full and not taken. Errors live in a
// three-row RAM with two read ports and one write port: every pixel writes its own
// error once and reads the row above one column ahead plus the row two above, while
// the two pixels to its left feed in from registers. Row and image fill tracking
// replaces clearing, so the unit takes pixels right from reset with no clearing pass.
module atkinson_error_diffusion_dither_unit #(
  parameter int unsigned MaxWidth = akd_pkg::DefMaxWidth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [akd_pkg::InDataW-1:0]       s_axis_tdata_i,   // [7:0] gray_sample
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [akd_pkg::OutDataW-1:0]      m_axis_tdata_o,   // [0] pixel_white,
                                                              // [8:1] column,
                                                              // [20:9] row, [23:21] zero
  output logic                              m_axis_tlast_o,   // last_pixel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [akd_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [akd_pkg::CfgDataW-1:0]      cfg_data_i
);

  localparam int unsigned XW    = $clog2(MaxWidth);
  localparam int unsigned Depth = 3 * MaxWidth;
  localparam int unsigned AddrW = $clog2(Depth);

  logic [akd_pkg::WidthRegW-1:0] width_q;
  logic [akd_pkg::RowW-1:0]      height_q;

  logic                          accept, adv;
  logic [XW-1:0]                 scan_x;
  logic [akd_pkg::RowW-1:0]      scan_y;
  akd_pkg::pix_flags_t           scan_flags;
  logic [AddrW-1:0]              scan_waddr, raddr_a, raddr_b;

  logic                          s1_valid_q, s1_valid_d;
  logic [akd_pkg::SampleW-1:0]   s1_sample_q;
  logic [XW-1:0]                 s1_x_q;
  logic [akd_pkg::RowW-1:0]      s1_y_q;
  akd_pkg::pix_flags_t           s1_flags_q;
  logic [AddrW-1:0]              s1_waddr_q;

  akd_pkg::err_word_t            rd_a, rd_b, wdata;
  logic                          white;

  logic                          out_valid_q, out_valid_d;
  logic                          out_white_q;
  logic [akd_pkg::ColumnW-1:0]   out_col_q;
  logic [akd_pkg::RowW-1:0]      out_row_q;
  logic                          out_last_q;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= akd_pkg::WidthReset;
      height_q <= akd_pkg::HeightReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (akd_pkg::cfg_reg_e'(cfg_index_i))
        akd_pkg::CfgImageWidth:  width_q  <= cfg_data_i[akd_pkg::WidthRegW-1:0];
        akd_pkg::CfgImageHeight: height_q <= cfg_data_i[akd_pkg::RowW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the error stage moves on whenever the output register is free or taken.
  assign adv             = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || adv;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  akd_scan #(
    .MaxWidth (MaxWidth),
    .XW       (XW),
    .AddrW    (AddrW)
  ) u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .image_width_i  (width_q),
    .image_height_i (height_q),
    .x_o            (scan_x),
    .y_o            (scan_y),
    .flags_o        (scan_flags),
    .waddr_o        (scan_waddr),
    .raddr_a_o      (raddr_a),
    .raddr_b_o      (raddr_b)
  );

  akd_error_ram #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (adv),
    .waddr_i   (s1_waddr_q),
    .wdata_i   (wdata),
    .re_i      (accept),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  akd_quant u_quant (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .sample_i (s1_sample_q),
    .flags_i  (s1_flags_q),
    .rd_a_i   (rd_a),
    .rd_b_i   (rd_b),
    .white_o  (white),
    .wdata_o  (wdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sample_q <= s_axis_tdata_i[akd_pkg::SampleW-1:0];
      s1_x_q      <= scan_x;
      s1_y_q      <= scan_y;
      s1_flags_q  <= scan_flags;
      s1_waddr_q  <= scan_waddr;
    end
    if (adv) begin
      out_white_q <= white;
      out_col_q   <= akd_pkg::ColumnW'(s1_x_q);
      out_row_q   <= s1_y_q;
      out_last_q  <= s1_flags_q.last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{akd_pkg::OutPadW{1'b0}}, out_row_q, out_col_q, out_white_q};
  assign m_axis_tlast_o  = out_last_q;

  // A held pixel in the error stage is never overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !adv) |-> !accept)
    else $error("error stage overwritten while held");

  // A pixel that leaves the error stage lands in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("pixel lost between error stage and output");

  // With nothing new accepted, a drained error stage is empty next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !accept) |=> !s1_valid_q)
    else $error("pixel duplicated in error stage");

endmodule
